>>> rtl/gaussian_box_muller_generator_core_assert.svh
// Assertion macros used by the generator core RTL.
`ifndef GAUSSIAN_BOX_MULLER_GENERATOR_CORE_ASSERT_SVH
`define GAUSSIAN_BOX_MULLER_GENERATOR_CORE_ASSERT_SVH

// Checked only while out of reset.
`define GBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define GBM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/gbm_pkg.sv
// Shared types, constants and tables of the Box-Muller generator.
package gbm_pkg;

    localparam int UNIFORM_BITS = 32;
    localparam int SAMPLE_BITS  = 32;
    localparam int ROUND_SHIFT  = 62 - SAMPLE_BITS;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] TWO_LN2_Q31 = 32'hB172_17F8;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam int CORDIC_STEPS = 30;

    typedef logic [UNIFORM_BITS-1:0] uniform_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [33:0] cordic_t;

    typedef struct packed {
        logic     saved;
        uniform_t u_radius;
        uniform_t u_angle;
    } item_t;

    // arctan(2^-i) in 2^32-turn units
    function automatic logic [31:0] turn_atan(input logic [4:0] idx);
        logic [31:0] a;
        a = 32'h0;
        case (idx)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2F9;
            5'd15: a = 32'h0000517C;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A2F;
            5'd19: a = 32'h00000517;
            5'd20: a = 32'h0000028B;
            5'd21: a = 32'h00000145;
            5'd22: a = 32'h000000A2;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000028;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000002;
            5'd29: a = 32'h00000001;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/gbm_front.sv
// Input side: takes words, tags each as computed or saved half, queues them.
module gbm_front import gbm_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  uniform_t       u_radius,
    input  uniform_t       u_angle,
    output logic           q_valid,
    output item_t          q_item,
    input  logic           q_pop
);

    item_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]  count_reg, count_next;
    logic                  kind_reg, kind_next;
    logic                  push, pop;

    assign s_tready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    // words alternate: compute a pair, then hand out its saved half
    always_comb begin
        kind_next   = push ? !kind_reg : kind_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_BITS'(push) - QCNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            kind_reg   <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            kind_reg   <= kind_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= '{saved: kind_reg, u_radius: u_radius, u_angle: u_angle};
        end
    end

endmodule

>>> rtl/gbm_radius.sv
// Iterative radius unit: normalize, log2 by squaring, scale, integer square root.
module gbm_radius import gbm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  uniform_t    u_radius,
    output logic        done,
    output logic [31:0] radius
);

    typedef enum logic [5:0] {
        R_IDLE = 6'b000001,
        R_NORM = 6'b000010,
        R_LOG  = 6'b000100,
        R_MULK = 6'b001000,
        R_SUM  = 6'b010000,
        R_SQRT = 6'b100000
    } rad_state_t;

    rad_state_t              state_reg, state_next;
    logic [UNIFORM_BITS:0]   n_reg, n_next;
    logic [5:0]              e_reg, e_next;
    logic [31:0]             x_reg, x_next;
    logic [31:0]             frac_reg, frac_next;
    logic [4:0]              k_reg, k_next;
    logic [37:0]             ik_reg, ik_next;
    logic [63:0]             fk_reg, fk_next;
    logic [63:0]             v_reg, v_next;
    logic [63:0]             res_reg, res_next;
    logic                    done_reg, done_next;

    logic [63:0]             sq;
    logic [32:0]             sq_hi;
    logic [37:0]             len;
    logic [39:0]             r2;
    logic [63:0]             bitv;
    logic [63:0]             trial;

    assign sq    = 64'(x_reg) * 64'(x_reg);
    assign sq_hi = sq[63:31];
    assign len   = {6'(UNIFORM_BITS) - e_reg, 32'h0} - 38'(frac_reg);
    assign r2    = {1'b0, ik_reg, 1'b0} + 40'(fk_reg[63:31]);
    assign bitv  = 64'd1 << (7'd62 - {1'b0, k_reg, 1'b0});
    assign trial = res_reg + bitv;

    assign done   = done_reg;
    assign radius = res_reg[31:0];

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        e_next     = e_reg;
        x_next     = x_reg;
        frac_next  = frac_reg;
        k_next     = k_reg;
        ik_next    = ik_reg;
        fk_next    = fk_reg;
        v_next     = v_reg;
        res_next   = res_reg;
        done_next  = done_reg;
        unique case (state_reg)
            R_IDLE: begin
                if (start) begin
                    n_next     = (UNIFORM_BITS + 1)'(u_radius) + 1'b1;
                    e_next     = 6'(UNIFORM_BITS);
                    done_next  = 1'b0;
                    state_next = R_NORM;
                end
            end
            R_NORM: begin
                if (n_reg[UNIFORM_BITS]) begin
                    x_next     = n_reg[UNIFORM_BITS:1];
                    frac_next  = '0;
                    k_next     = '0;
                    state_next = R_LOG;
                end else begin
                    n_next = n_reg << 1;
                    e_next = e_reg - 1'b1;
                end
            end
            R_LOG: begin
                // one fraction bit of log2 per squaring
                if (sq_hi[32]) begin
                    x_next    = sq_hi[32:1];
                    frac_next = {frac_reg[30:0], 1'b1};
                end else begin
                    x_next    = sq_hi[31:0];
                    frac_next = {frac_reg[30:0], 1'b0};
                end
                k_next = k_reg + 1'b1;
                if (k_reg == 5'd31) begin
                    state_next = R_MULK;
                end
            end
            R_MULK: begin
                ik_next    = 38'(len[37:32]) * 38'(TWO_LN2_Q31);
                fk_next    = 64'(len[31:0]) * 64'(TWO_LN2_Q31);
                state_next = R_SUM;
            end
            R_SUM: begin
                v_next     = {r2, 24'h0};
                res_next   = '0;
                k_next     = '0;
                state_next = R_SQRT;
            end
            R_SQRT: begin
                if (v_reg >= trial) begin
                    v_next   = v_reg - trial;
                    res_next = (res_reg >> 1) + bitv;
                end else begin
                    res_next = res_reg >> 1;
                end
                k_next = k_reg + 1'b1;
                if (k_reg == 5'd31) begin
                    done_next  = 1'b1;
                    state_next = R_IDLE;
                end
            end
            default: state_next = R_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg    <= n_next;
        e_reg    <= e_next;
        x_reg    <= x_next;
        frac_reg <= frac_next;
        k_reg    <= k_next;
        ik_reg   <= ik_next;
        fk_reg   <= fk_next;
        v_reg    <= v_next;
        res_reg  <= res_next;
    end

endmodule

>>> rtl/gbm_cordic.sv
// Iterative CORDIC: cosine and sine of a phase in turns, one rotation per cycle.
module gbm_cordic import gbm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     start,
    input  uniform_t u_angle,
    output logic     done,
    output cordic_t  cos_out,
    output cordic_t  sin_out
);

    typedef enum logic [1:0] {
        C_IDLE = 2'b01,
        C_ROT  = 2'b10
    } cor_state_t;

    cor_state_t  state_reg, state_next;
    cordic_t     x_reg, x_next;
    cordic_t     y_reg, y_next;
    cordic_t     z_reg, z_next;
    cordic_t     c_reg, c_next;
    cordic_t     s_reg, s_next;
    logic [1:0]  q_reg, q_next;
    logic [4:0]  i_reg, i_next;
    logic        done_reg, done_next;

    logic [31:0] phase, psum, resid;
    logic [1:0]  quad;
    cordic_t     xs, ys, at, xr, yr;

    assign phase = 32'(u_angle);
    assign psum  = phase + 32'h2000_0000;
    assign quad  = psum[31:30];
    assign resid = phase - {quad, 30'h0};
    assign xs    = x_reg >>> i_reg;
    assign ys    = y_reg >>> i_reg;
    assign at    = cordic_t'({2'b00, turn_atan(i_reg)});

    assign done    = done_reg;
    assign cos_out = c_reg;
    assign sin_out = s_reg;

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        c_next     = c_reg;
        s_next     = s_reg;
        q_next     = q_reg;
        i_next     = i_reg;
        done_next  = done_reg;
        xr         = '0;
        yr         = '0;
        unique case (state_reg)
            C_IDLE: begin
                if (start) begin
                    x_next     = CORDIC_X0;
                    y_next     = '0;
                    z_next     = cordic_t'({{2{resid[31]}}, resid});
                    q_next     = quad;
                    i_next     = '0;
                    done_next  = 1'b0;
                    state_next = C_ROT;
                end
            end
            C_ROT: begin
                if (!z_reg[33]) begin
                    xr     = x_reg - ys;
                    yr     = y_reg + xs;
                    z_next = z_reg - at;
                end else begin
                    xr     = x_reg + ys;
                    yr     = y_reg - xs;
                    z_next = z_reg + at;
                end
                x_next = xr;
                y_next = yr;
                i_next = i_reg + 1'b1;
                if (i_reg == 5'(CORDIC_STEPS - 1)) begin
                    // quadrant rotation by q * 90 degrees
                    unique case (q_reg)
                        2'd0: begin c_next = xr;  s_next = yr;  end
                        2'd1: begin c_next = -yr; s_next = xr;  end
                        2'd2: begin c_next = -xr; s_next = -yr; end
                        default: begin c_next = yr; s_next = -xr; end
                    endcase
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        c_reg <= c_next;
        s_reg <= s_next;
        q_reg <= q_next;
        i_reg <= i_next;
    end

endmodule

>>> rtl/gaussian_box_muller_generator_core.sv
// Box-Muller normal sample generator. Each input word carries two uniform fractions
// (u_radius low, u_angle high) and yields one Q4.28 sample. Words alternate: the first
// of a pair runs the radius unit (normalize, 32 log2 squarings, scaling in R_MULK and
// R_SUM, 32 square-root steps) alongside a 30-step CORDIC, then the states B_MULC,
// B_MULS, B_FIN and B_EMIT form the products and rounding; it returns r*cos and keeps
// r*sin. The next word returns that saved half with its inputs ignored. A two-entry
// queue lets the input side keep taking words while the back end computes, and the
// output register holds a result until taken.
module gaussian_box_muller_generator_core import gbm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] u_radius, [63:32] u_angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sample
    output logic [0:0]  m_tuser    // [0] from_saved
);

`include "gaussian_box_muller_generator_core_assert.svh"

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_CALC = 6'b000010,
        B_MULC = 6'b000100,
        B_MULS = 6'b001000,
        B_FIN  = 6'b010000,
        B_EMIT = 6'b100000
    } back_state_t;

    back_state_t state_reg, state_next;
    sample_t     saved_reg, saved_next;
    logic        saved_valid_reg, saved_valid_next;
    sample_t     cos_reg, cos_next;
    logic [63:0] prod_reg, prod_next;
    logic        m_valid_reg, m_valid_next;
    sample_t     m_sample_reg, m_sample_next;
    logic        m_saved_reg, m_saved_next;

    logic        q_valid, q_pop;
    item_t       q_item;
    logic        unit_start;
    logic        rad_done, cor_done;
    logic [31:0] radius;
    cordic_t     cos_v, sin_v;
    cordic_t     mul_b;
    logic signed [66:0] prod_full;
    logic        out_free;

    function automatic sample_t to_sample(input logic [63:0] prod);
        logic        neg;
        logic [63:0] mag, lim;
        neg = prod[63];
        mag = neg ? (64'd0 - prod) : prod;
        lim = 64'd1 << (SAMPLE_BITS - 1);
        mag = (mag + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
        if (neg) begin
            if (mag > lim) mag = lim;
            mag = 64'd0 - mag;
        end else if (mag > lim - 64'd1) begin
            mag = lim - 64'd1;
        end
        return sample_t'(mag[SAMPLE_BITS-1:0]);
    endfunction

    gbm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .u_radius (s_tdata[31:0]),
        .u_angle  (s_tdata[63:32]),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    gbm_radius u_radius (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (unit_start),
        .u_radius (q_item.u_radius),
        .done     (rad_done),
        .radius   (radius)
    );

    gbm_cordic u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (unit_start),
        .u_angle  (q_item.u_angle),
        .done     (cor_done),
        .cos_out  (cos_v),
        .sin_out  (sin_v)
    );

    assign out_free  = !m_valid_reg || m_tready;
    assign mul_b     = (state_reg == B_MULC) ? cos_v : sin_v;
    assign prod_full = $signed({1'b0, radius}) * mul_b;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_sample_reg;
    assign m_tuser  = m_saved_reg;

    always_comb begin
        state_next       = state_reg;
        saved_next       = saved_reg;
        saved_valid_next = saved_valid_reg;
        cos_next         = cos_reg;
        prod_next        = prod_reg;
        m_sample_next    = m_sample_reg;
        m_saved_next     = m_saved_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        q_pop            = 1'b0;
        unit_start       = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    if (q_item.saved) begin
                        if (out_free) begin
                            q_pop            = 1'b1;
                            m_valid_next     = 1'b1;
                            m_sample_next    = saved_reg;
                            m_saved_next     = 1'b1;
                            saved_next       = '0;
                            saved_valid_next = 1'b0;
                        end
                    end else begin
                        q_pop      = 1'b1;
                        unit_start = 1'b1;
                        state_next = B_CALC;
                    end
                end
            end
            B_CALC: begin
                if (rad_done && cor_done) state_next = B_MULC;
            end
            B_MULC: begin
                prod_next  = prod_full[63:0];
                state_next = B_MULS;
            end
            B_MULS: begin
                cos_next   = to_sample(prod_reg);
                prod_next  = prod_full[63:0];
                state_next = B_FIN;
            end
            B_FIN: begin
                saved_next       = to_sample(prod_reg);
                saved_valid_next = 1'b1;
                state_next       = B_EMIT;
            end
            B_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = cos_reg;
                    m_saved_next  = 1'b0;
                    state_next    = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= B_IDLE;
            saved_reg       <= '0;
            saved_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            saved_reg       <= saved_next;
            saved_valid_reg <= saved_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cos_reg      <= cos_next;
        prod_reg     <= prod_next;
        m_sample_reg <= m_sample_next;
        m_saved_reg  <= m_saved_next;
    end

    `GBM_ASSERT(a_saved_word_has_half, (q_pop && q_item.saved) |-> saved_valid_reg, "saved word popped with nothing saved")
    `GBM_ASSERT(a_emit_after_store, (state_reg == B_EMIT) |-> saved_valid_reg, "cosine half sent before sine half stored")
    `GBM_ASSERT(a_compute_when_empty, unit_start |-> !saved_valid_reg, "new pair started while a half is still saved")
    `GBM_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> (state_reg == B_IDLE && !m_tvalid), "reset left back end busy")

endmodule
